// ===== rtl/arlt_pkg.sv =====
// ----------------------------------------------------------------------------
// Aging route learning table package
// Shared sizes, operation and status codes, and the table entry type.
// ----------------------------------------------------------------------------
package arlt_pkg;

    localparam int DEPTH    = 16;
    localparam int KEY_BITS = 64;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    localparam int OP_W     = 2;
    localparam int KEY_W    = 64;
    localparam int ADDR_W   = 48;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 4;
    localparam int SLOT_W   = 4;
    localparam int TALLY_W  = 5;

    localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd30000;

    localparam logic [OP_W-1:0] OP_LEARN  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_SWEEP  = 2'd2;
    localparam logic [OP_W-1:0] OP_FANOUT = 2'd3;

    localparam logic [STATUS_W-1:0] ST_UPDATED  = 4'd0;
    localparam logic [STATUS_W-1:0] ST_REUSED   = 4'd1;
    localparam logic [STATUS_W-1:0] ST_APPENDED = 4'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 4'd3;
    localparam logic [STATUS_W-1:0] ST_HIT      = 4'd4;
    localparam logic [STATUS_W-1:0] ST_MISS     = 4'd5;
    localparam logic [STATUS_W-1:0] ST_STALE    = 4'd6;
    localparam logic [STATUS_W-1:0] ST_EXPIRED  = 4'd7;
    localparam logic [STATUS_W-1:0] ST_TARGET   = 4'd8;
    localparam logic [STATUS_W-1:0] ST_DONE     = 4'd9;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [ADDR_W-1:0]   addr;
        logic [TIME_W-1:0]   seen;
        logic                valid;
    } t_entry;

endpackage

// ===== rtl/arlt_cell.sv =====
// ----------------------------------------------------------------------------
// Aging route learning table cell
// Holds one table entry; takes its neighbor's entry on a shift or a new
// entry on a load.
// ----------------------------------------------------------------------------
module arlt_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  logic            i_load,
    input  arlt_pkg::t_entry i_shift_in,
    input  arlt_pkg::t_entry i_load_val,
    output arlt_pkg::t_entry o_entry
);
    import arlt_pkg::*;

    logic                r_valid;
    logic [KEY_BITS-1:0] r_key;
    logic [ADDR_W-1:0]   r_addr;
    logic [TIME_W-1:0]   r_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_shift_in.valid;
        end else if (i_load) begin
            r_valid <= i_load_val.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key  <= i_shift_in.key;
            r_addr <= i_shift_in.addr;
            r_seen <= i_shift_in.seen;
        end else if (i_load) begin
            r_key  <= i_load_val.key;
            r_addr <= i_load_val.addr;
            r_seen <= i_load_val.seen;
        end
    end

    assign o_entry = '{key: r_key, addr: r_addr, seen: r_seen, valid: r_valid};

endmodule

// ===== rtl/aging_route_learning_table_core.sv =====
// ----------------------------------------------------------------------------
// Aging route learning table core
// Key to node address table with aging, kept in a ring of cells that rotates
// one slot per cycle past a shared head that learns, looks up, expires and lists.
// ----------------------------------------------------------------------------
// Channel   Direction  Transfer condition        Payload
// command   in         start && !busy            i_op, i_key, i_node_addr, i_now_ms
// result    out        o_res_strobe              o_status .. o_last
// config    in         i_cfg_we                  i_cfg_wdata (route timeout)
//
// Learn, lookup and sweep keep busy high for one pass, fanout for two
// passes: one full turn of the cell ring per pass, one slot a cycle at the
// head, plus a final write or done state that forms the final result.
// Results are registered after they are formed, at most one per cycle.
// Reset is synchronous and clears all valid bits and the fill count at once.
// The receiver cannot stall; every result is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module aging_route_learning_table_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [arlt_pkg::OP_W-1:0]         i_op,
    input  logic [arlt_pkg::KEY_W-1:0]        i_key,
    input  logic [arlt_pkg::ADDR_W-1:0]       i_node_addr,
    input  logic [arlt_pkg::TIME_W-1:0]       i_now_ms,
    input  logic                              i_cfg_we,
    input  logic [arlt_pkg::TIME_W-1:0]       i_cfg_wdata,
    output logic                              o_res_strobe,
    output logic [arlt_pkg::STATUS_W-1:0]     o_status,
    output logic [arlt_pkg::ADDR_W-1:0]       o_found_addr,
    output logic [arlt_pkg::KEY_W-1:0]        o_offline_key,
    output logic [arlt_pkg::SLOT_W-1:0]       o_slot,
    output logic [arlt_pkg::TALLY_W-1:0]      o_tally,
    output logic                              o_last
);
    import arlt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_LIST  = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_step, n_step;
    logic [OP_W-1:0]     r_op, n_op;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [ADDR_W-1:0]   r_addr_in, n_addr_in;
    logic [TIME_W-1:0]   r_now, n_now;
    logic [TIME_W-1:0]   r_timeout, n_timeout;
    logic [CNT_W-1:0]    r_used, n_used;
    logic                r_hit, n_hit;
    logic [IDX_W-1:0]    r_hit_slot, n_hit_slot;
    logic                r_inv, n_inv;
    logic [IDX_W-1:0]    r_inv_slot, n_inv_slot;
    logic [STATUS_W-1:0] r_pend_status, n_pend_status;
    logic [ADDR_W-1:0]   r_pend_addr, n_pend_addr;
    logic [CNT_W-1:0]    r_tally, n_tally;

    logic                r_o_strobe, n_o_strobe;
    logic [STATUS_W-1:0] r_o_status, n_o_status;
    logic [ADDR_W-1:0]   r_o_addr, n_o_addr;
    logic [KEY_W-1:0]    r_o_okey, n_o_okey;
    logic [SLOT_W-1:0]   r_o_slot, n_o_slot;
    logic [TALLY_W-1:0]  r_o_tally, n_o_tally;
    logic                r_o_last, n_o_last;

    t_entry              w_cell [DEPTH];
    t_entry              w_head, w_tail, w_wr_ent;
    logic [DEPTH-1:0]    w_load;
    logic                w_shift, w_clr, w_in_range, w_stale, w_key_eq, w_last_step;
    logic [TIME_W-1:0]   w_age;
    logic                w_wr_en, w_append;
    logic [IDX_W-1:0]    w_target;
    logic [STATUS_W-1:0] w_wr_status;

    assign w_shift  = (r_state == S_SCAN) || (r_state == S_LIST);
    assign w_wr_ent = '{key: r_key, addr: r_addr_in, seen: r_now, valid: 1'b1};

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            t_entry w_next;
            if (k == DEPTH - 1) begin : g_tail
                assign w_next = w_tail;
            end else begin : g_mid
                assign w_next = w_cell[k + 1];
            end
            assign w_load[k] = (r_state == S_WRITE) && w_wr_en &&
                               (w_target == IDX_W'(k));
            arlt_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_shift    (w_shift),
                .i_load     (w_load[k]),
                .i_shift_in (w_next),
                .i_load_val (w_wr_ent),
                .o_entry    (w_cell[k])
            );
        end
    endgenerate

    assign w_head      = w_cell[0];
    assign w_in_range  = CNT_W'(r_step) < r_used;
    assign w_age       = r_now - w_head.seen;
    assign w_stale     = w_age >= r_timeout;
    assign w_key_eq    = w_head.key == r_key;
    assign w_last_step = r_step == IDX_W'(DEPTH - 1);

    always_comb begin
        w_tail       = w_head;
        w_tail.valid = w_head.valid & ~w_clr;
    end

    always_comb begin
        w_wr_en     = 1'b0;
        w_append    = 1'b0;
        w_target    = r_hit_slot;
        w_wr_status = ST_FULL;
        if (r_hit) begin
            w_wr_en     = 1'b1;
            w_wr_status = ST_UPDATED;
        end else if (r_inv) begin
            w_wr_en     = 1'b1;
            w_target    = r_inv_slot;
            w_wr_status = ST_REUSED;
        end else if (r_used != CNT_W'(DEPTH)) begin
            w_wr_en     = 1'b1;
            w_append    = 1'b1;
            w_target    = r_used[IDX_W-1:0];
            w_wr_status = ST_APPENDED;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_step        = r_step;
        n_op          = r_op;
        n_key         = r_key;
        n_addr_in     = r_addr_in;
        n_now         = r_now;
        n_timeout     = i_cfg_we ? i_cfg_wdata : r_timeout;
        n_used        = r_used;
        n_hit         = r_hit;
        n_hit_slot    = r_hit_slot;
        n_inv         = r_inv;
        n_inv_slot    = r_inv_slot;
        n_pend_status = r_pend_status;
        n_pend_addr   = r_pend_addr;
        n_tally       = r_tally;
        n_o_strobe    = 1'b0;
        n_o_status    = ST_UPDATED;
        n_o_addr      = '0;
        n_o_okey      = '0;
        n_o_slot      = '0;
        n_o_tally     = '0;
        n_o_last      = 1'b0;
        w_clr         = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state   = S_SCAN;
                    n_step    = '0;
                    n_op      = i_op;
                    n_key     = i_key[KEY_BITS-1:0];
                    n_addr_in = i_node_addr;
                    n_now     = i_now_ms;
                    n_hit     = 1'b0;
                    n_inv     = 1'b0;
                    n_tally   = '0;
                end
            end
            S_SCAN: begin
                n_step = w_last_step ? '0 : r_step + 1'b1;
                if (w_in_range) begin
                    case (r_op) inside
                        OP_LEARN: begin
                            if (!r_hit && w_key_eq) begin
                                n_hit      = 1'b1;
                                n_hit_slot = r_step;
                            end
                            if (!r_inv && !w_head.valid) begin
                                n_inv      = 1'b1;
                                n_inv_slot = r_step;
                            end
                        end
                        OP_LOOKUP: begin
                            if (!r_hit && w_head.valid && w_key_eq) begin
                                n_hit      = 1'b1;
                                n_hit_slot = r_step;
                                if (w_stale) begin
                                    w_clr         = 1'b1;
                                    n_pend_status = ST_STALE;
                                    n_pend_addr   = '0;
                                end else begin
                                    n_pend_status = ST_HIT;
                                    n_pend_addr   = w_head.addr;
                                end
                            end
                        end
                        OP_SWEEP, OP_FANOUT: begin
                            if (w_head.valid && w_stale) begin
                                w_clr      = 1'b1;
                                n_o_strobe = 1'b1;
                                n_o_status = ST_EXPIRED;
                                n_o_okey   = KEY_W'(w_head.key);
                                n_o_slot   = SLOT_W'(r_step);
                                n_tally    = r_tally + 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (w_last_step) begin
                    if (r_op == OP_LEARN) begin
                        n_state = S_WRITE;
                    end else if (r_op == OP_FANOUT) begin
                        n_state = S_LIST;
                        n_tally = '0;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_LIST: begin
                n_step = w_last_step ? '0 : r_step + 1'b1;
                if (w_in_range && w_head.valid) begin
                    n_o_strobe = 1'b1;
                    n_o_status = ST_TARGET;
                    n_o_addr   = w_head.addr;
                    n_o_slot   = SLOT_W'(r_step);
                    n_tally    = r_tally + 1'b1;
                end
                if (w_last_step) begin
                    n_state = S_DONE;
                end
            end
            S_WRITE: begin
                n_o_strobe = 1'b1;
                n_o_last   = 1'b1;
                n_o_status = w_wr_status;
                n_o_slot   = w_wr_en ? SLOT_W'(w_target) : '0;
                if (w_append) begin
                    n_used = r_used + 1'b1;
                end
                n_state = S_IDLE;
            end
            S_DONE: begin
                n_o_strobe = 1'b1;
                n_o_last   = 1'b1;
                if (r_op == OP_LOOKUP) begin
                    if (r_hit) begin
                        n_o_status = r_pend_status;
                        n_o_addr   = r_pend_addr;
                        n_o_slot   = SLOT_W'(r_hit_slot);
                        if (r_pend_status == ST_STALE) begin
                            n_o_okey = KEY_W'(r_key);
                        end
                    end else begin
                        n_o_status = ST_MISS;
                    end
                end else begin
                    n_o_status = ST_DONE;
                    n_o_tally  = TALLY_W'(r_tally);
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_used     <= '0;
            r_timeout  <= TIMEOUT_RST;
            r_o_strobe <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_used     <= n_used;
            r_timeout  <= n_timeout;
            r_o_strobe <= n_o_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_key         <= n_key;
        r_addr_in     <= n_addr_in;
        r_now         <= n_now;
        r_hit         <= n_hit;
        r_hit_slot    <= n_hit_slot;
        r_inv         <= n_inv;
        r_inv_slot    <= n_inv_slot;
        r_pend_status <= n_pend_status;
        r_pend_addr   <= n_pend_addr;
        r_tally       <= n_tally;
        r_o_status    <= n_o_status;
        r_o_addr      <= n_o_addr;
        r_o_okey      <= n_o_okey;
        r_o_slot      <= n_o_slot;
        r_o_tally     <= n_o_tally;
        r_o_last      <= n_o_last;
    end

    assign busy          = r_state != S_IDLE;
    assign o_res_strobe  = r_o_strobe;
    assign o_status      = r_o_status;
    assign o_found_addr  = r_o_addr;
    assign o_offline_key = r_o_okey;
    assign o_slot        = r_o_slot;
    assign o_tally       = r_o_tally;
    assign o_last        = r_o_last;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(DEPTH))
        else $error("Fill count exceeds the table depth.");

    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_step == '0))
        else $error("Ring is not aligned while idle.");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted command did not raise busy.");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_last) |=> !o_res_strobe)
        else $error("Result transfer directly follows a final result.");

    a_load_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_shift && (w_load != '0)))
        else $error("Cell load during ring rotation.");

endmodule
